FILE: rtl/qtg_pkg.sv
// Shared types and codes of the quintic trajectory generator.
`timescale 1ns / 1ps
package qtg_pkg;
	localparam int KIND_W  = 2;
	localparam int TIME_W  = 48;
	localparam int COEF_W  = 32;
	localparam int NCOEF   = 6;
	localparam int OUT_MAX = 8;

	typedef logic [TIME_W-1:0]        time_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [KIND_W-1:0]        kind_t;

	localparam kind_t KIND_TICK   = 2'd0;
	localparam kind_t KIND_BEGIN  = 2'd1;
	localparam kind_t KIND_APPEND = 2'd2;
	localparam kind_t KIND_WRITE  = 2'd3;
endpackage

FILE: rtl/quintic_trajectory_generator_unit.sv
// Top level of the quintic trajectory generator: segment table, search and Horner evaluation.
// Tick: searches the table entry by entry, then after a setup step loads each joint's coefficients
//   and runs 12 Horner multiply/add pairs, only the position pairs when holding; 1 beat per joint.
// Append: stores the entry and zeroes its MAX_JOINTS*6 coefficients; a full table gives one beat.
// Begin: checks each entry, keeping or dropping it, and copies the coefficients of each kept entry that moves.
// Write coefficient: one item at a time. Reset clears control state, not memories.
`timescale 1ns / 1ps
module quintic_trajectory_generator_unit #(
	parameter int MAX_JOINTS   = 8,
	parameter int MAX_SEGMENTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  qtg_pkg::kind_t        kind,
	input  qtg_pkg::time_t        time_value,
	input  logic [2:0]            joint_sel,
	input  logic [2:0]            coef_index,
	input  qtg_pkg::coef_t        coef_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            joint_id,
	output qtg_pkg::coef_t        position,
	output qtg_pkg::coef_t        velocity,
	output qtg_pkg::coef_t        acceleration,
	output logic                  holding,
	output logic                  status,
	output logic                  last_of_run,
	input  logic                  cfg_we,
	input  logic [3:0]            cfg_wdata
);
	// Coefficient entries per segment, and address widths of the two memories.
	localparam int CPS     = MAX_JOINTS * qtg_pkg::NCOEF;
	localparam int SEG_AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SEG_CW  = $clog2(MAX_SEGMENTS + 1);
	localparam int COEF_AW = $clog2(MAX_SEGMENTS * CPS);
	localparam int CI_W    = $clog2(CPS + 1);
	localparam int NMAX    = (MAX_JOINTS < qtg_pkg::OUT_MAX) ? MAX_JOINTS : qtg_pkg::OUT_MAX;
	localparam int META_W  = 2 * qtg_pkg::TIME_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SRD   = 4'd1;
	localparam logic [3:0] ST_SCHK  = 4'd2;
	localparam logic [3:0] ST_PREP  = 4'd3;
	localparam logic [3:0] ST_LOAD  = 4'd4;
	localparam logic [3:0] ST_INIT  = 4'd5;
	localparam logic [3:0] ST_MUL   = 4'd6;
	localparam logic [3:0] ST_ADD   = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;
	localparam logic [3:0] ST_BRD   = 4'd9;
	localparam logic [3:0] ST_BCHK  = 4'd10;
	localparam logic [3:0] ST_BCOPY = 4'd11;
	localparam logic [3:0] ST_AZERO = 4'd12;
	localparam logic [3:0] ST_EFULL = 4'd13;

	// Segment table: {start, duration} per entry, and the coefficient store.
	logic [META_W-1:0]     meta_mem [MAX_SEGMENTS];
	qtg_pkg::coef_t        coef_mem [MAX_SEGMENTS * CPS];
	logic [META_W-1:0]     meta_rdata;
	qtg_pkg::coef_t        coef_rdata;
	logic [SEG_AW-1:0]     meta_raddr, meta_waddr;
	logic                  meta_we;
	logic [META_W-1:0]     meta_wdata;
	logic [COEF_AW-1:0]    coef_raddr, coef_waddr;
	logic                  coef_we;
	qtg_pkg::coef_t        coef_wdata;

	logic [3:0]            state_q;
	logic [SEG_CW-1:0]     seg_count_q, rd_q, w_q;
	logic [SEG_AW-1:0]     sel_q;
	logic                  found_q;
	qtg_pkg::time_t        last_tick_q, next_start_q, tv_q, sel_start_q, sel_dur_q;
	logic [3:0]            jc_q;
	logic [2:0]            j_q, lastj_q;
	logic [2:0]            lcnt_q;
	logic [CI_W-1:0]       ci_q;
	logic [1:0]            phase_q;
	logic [2:0]            step_q;
	logic                  hold_q;
	logic signed [31:0]    t_q;
	qtg_pkg::coef_t        c_q [qtg_pkg::NCOEF];
	qtg_pkg::coef_t        hacc_q, pos_q, vel_q;
	logic signed [63:0]    prod_q;

	logic                  out_valid_q;
	logic [2:0]            joint_id_q;
	qtg_pkg::coef_t        position_q, velocity_q, acceleration_q;
	logic                  holding_q, status_q, last_q;

	logic                  accept, out_free;
	qtg_pkg::time_t        rstart, rdur;
	logic [qtg_pkg::TIME_W:0] rend, sel_end, ns_sum;
	logic                  keep;
	qtg_pkg::time_t        t_full;
	logic                  t_hold;
	qtg_pkg::coef_t        operand, init_val, step_res;
	logic [2:0]            last_step;
	logic [2:0]            n_last;

	function automatic qtg_pkg::coef_t sat32(input logic signed [63:0] v);
		qtg_pkg::coef_t r;
		if (v > 64'sh7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh8000_0000)
			r = -32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Derivative coefficient k*c, clamped to 32 bits.
	function automatic qtg_pkg::coef_t mulk(input qtg_pkg::coef_t c, input logic [4:0] k);
		logic signed [63:0] p;
		p = 64'(c) * $signed({59'd0, k});
		return sat32(p);
	endfunction

	function automatic logic [COEF_AW-1:0] seg_base(input logic [SEG_AW-1:0] s);
		return COEF_AW'(int'(s) * CPS);
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign rstart  = meta_rdata[META_W-1:qtg_pkg::TIME_W];
	assign rdur    = meta_rdata[qtg_pkg::TIME_W-1:0];
	assign rend    = {1'b0, rstart} + {1'b0, rdur};
	assign keep    = (rend > {1'b0, last_tick_q}) && (rstart < tv_q);
	assign sel_end = {1'b0, sel_start_q} + {1'b0, sel_dur_q};
	assign t_hold  = sel_end < {1'b0, tv_q};
	assign t_full  = t_hold ? sel_dur_q : (tv_q - sel_start_q);
	assign ns_sum  = {1'b0, next_start_q} + {1'b0, time_value};

	// Joints per tick: register clamped to at least one and at most the supported count.
	always_comb begin
		if (jc_q == 4'd0)
			n_last = 3'd0;
		else if (int'(jc_q) > NMAX)
			n_last = 3'(NMAX - 1);
		else
			n_last = 3'(jc_q - 4'd1);
	end

	// Horner schedule: position, velocity and acceleration polynomials in turn.
	always_comb begin
		case (phase_q)
			2'd0: begin
				init_val  = c_q[5];
				last_step = 3'd4;
			end
			2'd1: begin
				init_val  = mulk(c_q[5], 5'd5);
				last_step = 3'd3;
			end
			default: begin
				init_val  = mulk(c_q[5], 5'd20);
				last_step = 3'd2;
			end
		endcase
		operand = c_q[0];
		case ({phase_q, step_q})
			{2'd0, 3'd0}: operand = c_q[4];
			{2'd0, 3'd1}: operand = c_q[3];
			{2'd0, 3'd2}: operand = c_q[2];
			{2'd0, 3'd3}: operand = c_q[1];
			{2'd0, 3'd4}: operand = c_q[0];
			{2'd1, 3'd0}: operand = mulk(c_q[4], 5'd4);
			{2'd1, 3'd1}: operand = mulk(c_q[3], 5'd3);
			{2'd1, 3'd2}: operand = mulk(c_q[2], 5'd2);
			{2'd1, 3'd3}: operand = c_q[1];
			{2'd2, 3'd0}: operand = mulk(c_q[4], 5'd12);
			{2'd2, 3'd1}: operand = mulk(c_q[3], 5'd6);
			{2'd2, 3'd2}: operand = mulk(c_q[2], 5'd2);
			default:      operand = c_q[0];
		endcase
		step_res = sat32((prod_q >>> 16) + 64'(operand));
	end

	// Memory port steering. Each state drives at most one read and one write per memory.
	always_comb begin
		meta_raddr = rd_q[SEG_AW-1:0];
		meta_we    = 1'b0;
		meta_waddr = seg_count_q[SEG_AW-1:0];
		meta_wdata = {next_start_q, time_value};
		coef_raddr = seg_base(sel_q) + COEF_AW'(int'(j_q) * qtg_pkg::NCOEF + int'(lcnt_q));
		coef_we    = 1'b0;
		coef_waddr = seg_base(seg_count_q[SEG_AW-1:0] - SEG_AW'(1))
			+ COEF_AW'(int'(joint_sel) * qtg_pkg::NCOEF + int'(coef_index));
		coef_wdata = coef_value;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == qtg_pkg::KIND_APPEND && int'(seg_count_q) < MAX_SEGMENTS)
					meta_we = 1'b1;
				if (accept && kind == qtg_pkg::KIND_WRITE && seg_count_q != '0
					&& int'(joint_sel) < MAX_JOINTS && coef_index < 3'd6)
					coef_we = 1'b1;
			end
			ST_BCHK: begin
				meta_waddr = w_q[SEG_AW-1:0];
				meta_wdata = meta_rdata;
				meta_we    = keep && (w_q != rd_q);
			end
			ST_BCOPY: begin
				coef_raddr = seg_base(rd_q[SEG_AW-1:0]) + COEF_AW'(ci_q);
				coef_waddr = seg_base(w_q[SEG_AW-1:0]) + COEF_AW'(ci_q) - COEF_AW'(1);
				coef_wdata = coef_rdata;
				coef_we    = (ci_q != '0);
			end
			ST_AZERO: begin
				coef_waddr = seg_base(seg_count_q[SEG_AW-1:0]) + COEF_AW'(ci_q);
				coef_wdata = '0;
				coef_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[meta_waddr] <= meta_wdata;
		meta_rdata <= meta_mem[meta_raddr];
	end

	always_ff @(posedge clk) begin
		if (coef_we)
			coef_mem[coef_waddr] <= coef_wdata;
		coef_rdata <= coef_mem[coef_raddr];
	end

	// Working registers of the evaluation; they carry no control meaning.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && lcnt_q != 3'd0)
			c_q[lcnt_q - 3'd1] <= coef_rdata;
		if (state_q == ST_INIT)
			hacc_q <= init_val;
		if (state_q == ST_MUL)
			prod_q <= hacc_q * t_q;
		if (state_q == ST_ADD) begin
			hacc_q <= step_res;
			if (step_q == last_step && phase_q == 2'd0)
				pos_q <= step_res;
			if (step_q == last_step && phase_q == 2'd1)
				vel_q <= step_res;
		end
		if (state_q == ST_SCHK && rstart < tv_q) begin
			sel_start_q <= rstart;
			sel_dur_q   <= rdur;
		end
		if (state_q == ST_PREP)
			t_q <= (t_full > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(t_full[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			seg_count_q    <= '0;
			last_tick_q    <= '0;
			next_start_q   <= '0;
			tv_q           <= '0;
			jc_q           <= 4'd1;
			rd_q           <= '0;
			w_q            <= '0;
			sel_q          <= '0;
			found_q        <= 1'b0;
			j_q            <= '0;
			lastj_q        <= '0;
			lcnt_q         <= '0;
			ci_q           <= '0;
			phase_q        <= '0;
			step_q         <= '0;
			hold_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			joint_id_q     <= '0;
			position_q     <= '0;
			velocity_q     <= '0;
			acceleration_q <= '0;
			holding_q      <= 1'b0;
			status_q       <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_we)
				jc_q <= cfg_wdata;
			// The output register loads a new beat, or empties once its beat is taken.
			if ((state_q == ST_EMIT || state_q == ST_EFULL) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tv_q <= time_value;
						rd_q <= '0;
						w_q  <= '0;
						ci_q <= '0;
						case (kind)
							qtg_pkg::KIND_TICK: begin
								last_tick_q <= time_value;
								found_q     <= 1'b0;
								state_q     <= ST_SRD;
							end
							qtg_pkg::KIND_BEGIN: begin
								state_q <= ST_BRD;
							end
							qtg_pkg::KIND_APPEND: begin
								if (int'(seg_count_q) < MAX_SEGMENTS) begin
									next_start_q <= ns_sum[qtg_pkg::TIME_W]
										? '1 : ns_sum[qtg_pkg::TIME_W-1:0];
									state_q <= ST_AZERO;
								end else begin
									state_q <= ST_EFULL;
								end
							end
							default: begin
							end
						endcase
					end
				end
				// Search the leading run of started segments, one entry per read.
				ST_SRD: begin
					if (rd_q < seg_count_q)
						state_q <= ST_SCHK;
					else
						state_q <= found_q ? ST_PREP : ST_IDLE;
				end
				ST_SCHK: begin
					if (rstart < tv_q) begin
						found_q <= 1'b1;
						sel_q   <= rd_q[SEG_AW-1:0];
						rd_q    <= rd_q + SEG_CW'(1);
						state_q <= ST_SRD;
					end else begin
						state_q <= found_q ? ST_PREP : ST_IDLE;
					end
				end
				ST_PREP: begin
					hold_q  <= t_hold;
					lastj_q <= n_last;
					j_q     <= '0;
					lcnt_q  <= '0;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					lcnt_q <= lcnt_q + 3'd1;
					if (lcnt_q == 3'd6) begin
						phase_q <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (step_q != last_step) begin
						step_q  <= step_q + 3'd1;
						state_q <= ST_MUL;
					end else if ((phase_q == 2'd0 && hold_q) || phase_q == 2'd2) begin
						state_q <= ST_EMIT;
					end else begin
						phase_q <= phase_q + 2'd1;
						state_q <= ST_INIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						joint_id_q     <= j_q;
						position_q     <= pos_q;
						velocity_q     <= hold_q ? '0 : vel_q;
						acceleration_q <= hold_q ? '0 : hacc_q;
						holding_q      <= hold_q;
						status_q       <= 1'b0;
						last_q         <= (j_q == lastj_q);
						if (j_q == lastj_q) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + 3'd1;
							lcnt_q  <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				// Compaction: surviving entries move down, coefficients copied one a cycle.
				ST_BRD: begin
					if (rd_q < seg_count_q) begin
						state_q <= ST_BCHK;
					end else begin
						seg_count_q  <= w_q;
						next_start_q <= tv_q;
						state_q      <= ST_IDLE;
					end
				end
				ST_BCHK: begin
					ci_q <= '0;
					if (keep && w_q != rd_q) begin
						state_q <= ST_BCOPY;
					end else begin
						if (keep)
							w_q <= w_q + SEG_CW'(1);
						rd_q    <= rd_q + SEG_CW'(1);
						state_q <= ST_BRD;
					end
				end
				ST_BCOPY: begin
					ci_q <= ci_q + CI_W'(1);
					if (int'(ci_q) == CPS) begin
						w_q     <= w_q + SEG_CW'(1);
						rd_q    <= rd_q + SEG_CW'(1);
						state_q <= ST_BRD;
					end
				end
				ST_AZERO: begin
					ci_q <= ci_q + CI_W'(1);
					if (int'(ci_q) == CPS - 1) begin
						seg_count_q <= seg_count_q + SEG_CW'(1);
						state_q     <= ST_IDLE;
					end
				end
				ST_EFULL: begin
					if (out_free) begin
						joint_id_q     <= '0;
						position_q     <= '0;
						velocity_q     <= '0;
						acceleration_q <= '0;
						holding_q      <= 1'b0;
						status_q       <= 1'b1;
						last_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign joint_id     = joint_id_q;
	assign position     = position_q;
	assign velocity     = velocity_q;
	assign acceleration = acceleration_q;
	assign holding      = holding_q;
	assign status       = status_q;
	assign last_of_run  = last_q;

	// The table never holds more than its capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(seg_count_q) <= MAX_SEGMENTS)
		else $error("segment count above capacity");

	// A rejected append is a single closing beat with zero payload.
	a_full_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last_of_run && position == '0 && !holding)
		else $error("bad table-full beat");

	// Holding beats carry zero velocity and acceleration.
	a_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && holding |-> velocity == '0 && acceleration == '0)
		else $error("nonzero motion while holding");

	// A compaction copy always moves an entry to a lower slot.
	a_copy_down: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BCOPY |-> w_q < rd_q)
		else $error("copy destination not below source");
endmodule
